>>> rtl/core/rpb_pkg.sv
// Package with shared constants and types for the row palette builder.
package rpb_pkg;

    localparam int MaxColors  = 256;
    localparam int IdxW       = 8;
    localparam int LenW       = 9;
    localparam int ColorW     = 24;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL1   = 3'd2,
        ST_FULLN   = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

>>> rtl/core/rpb_ram.sv
// Generic single-port RAM with registered read data.
module rpb_ram #(
    parameter int Width = 24,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One address per cycle: written when i_we is set, and read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/row_palette_builder_core.sv
// Top level of the row palette builder: scan controller around the palette RAM.
// A new color or a full palette scans all N entries before the result; a hit stops
// the scan at its entry, and an ignored pixel is answered from idle without a scan.
// A new pixel is accepted only after the previous result has been taken; the scan
// reads entries through the single RAM read port.
// Reset clears counts and flags and sets the first-row flag; palette contents stay undefined until written.
module row_palette_builder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic        s_axis_tlast,  // row_end
    input  logic        s_axis_tuser,  // first_of_region
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // color_index[7:0], palette_length[16:8], zeros
    output logic [2:0]  m_axis_tuser   // status
);

    rpb_pkg::t_state r_state, n_state;
    logic [rpb_pkg::LenW-1:0]   r_cnt, n_cnt, r_com, n_com;
    logic                       r_first, n_first, r_stop, n_stop;
    logic [rpb_pkg::ColorW-1:0] r_color, n_color;
    logic                       r_last, n_last;
    logic [rpb_pkg::LenW-1:0]   r_ptr, n_ptr;
    logic                       r_pend, n_pend;
    logic [rpb_pkg::IdxW-1:0]   r_oidx, n_oidx;
    rpb_pkg::t_status           r_ost, n_ost;
    logic                       r_ov, n_ov;
    logic                       we;
    logic [rpb_pkg::IdxW-1:0]   addr;
    logic [rpb_pkg::ColorW-1:0] rdata;
    logic [rpb_pkg::ColorW-1:0] in_color;

    // Color word packed red high, blue low, as in the match compare.
    assign in_color = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    rpb_ram #(.Width(rpb_pkg::ColorW), .Depth(rpb_pkg::MaxColors)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (r_color),
        .o_rdata (rdata)
    );

    assign s_axis_tready = (r_state == rpb_pkg::S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'd0, r_cnt, r_oidx};
    assign m_axis_tuser  = r_ost;
    assign addr          = r_ptr[rpb_pkg::IdxW-1:0];

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpb_pkg::S_IDLE;
            r_cnt   <= '0;
            r_com   <= '0;
            r_first <= 1'b1;
            r_stop  <= 1'b0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_com   <= n_com;
            r_first <= n_first;
            r_stop  <= n_stop;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
        end
        r_color <= n_color;
        r_last  <= n_last;
        r_ptr   <= n_ptr;
        r_oidx  <= n_oidx;
        r_ost   <= n_ost;
    end

    // Scan sequencer: reads entries in order, compares one per cycle, then appends or stops when full.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_com   = r_com;
        n_first = r_first;
        n_stop  = r_stop;
        n_color = r_color;
        n_last  = r_last;
        n_ptr   = r_ptr;
        n_pend  = 1'b0;
        n_oidx  = r_oidx;
        n_ost   = r_ost;
        n_ov    = r_ov && !m_axis_tready;
        we      = 1'b0;
        case (r_state)
            rpb_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_color = in_color;
                    n_last  = s_axis_tlast;
                    n_ptr   = '0;
                    if (s_axis_tuser) begin
                        n_cnt   = '0;
                        n_com   = '0;
                        n_first = 1'b1;
                        n_stop  = 1'b0;
                    end
                    if (r_stop && !s_axis_tuser) begin
                        n_oidx = '0;
                        n_ost  = rpb_pkg::ST_IGNORED;
                        n_ov   = 1'b1;
                    end else begin
                        n_state = rpb_pkg::S_SCAN;
                    end
                end
            end
            rpb_pkg::S_SCAN: begin
                // Compare the entry read last cycle.
                if (r_pend && rdata == r_color) begin
                    n_oidx  = 8'(r_ptr - 9'd1);
                    n_ost   = rpb_pkg::ST_FOUND;
                    n_state = rpb_pkg::S_OUT;
                end else if (r_ptr < r_cnt) begin
                    n_ptr  = r_ptr + 9'd1;
                    n_pend = 1'b1;
                end else if (r_cnt < 9'(rpb_pkg::MaxColors)) begin
                    we      = 1'b1;
                    n_oidx  = r_cnt[rpb_pkg::IdxW-1:0];
                    n_cnt   = r_cnt + 9'd1;
                    n_ost   = rpb_pkg::ST_ADDED;
                    n_state = rpb_pkg::S_OUT;
                end else begin
                    n_oidx  = '0;
                    n_stop  = 1'b1;
                    n_state = rpb_pkg::S_OUT;
                    if (r_first) begin
                        n_ost = rpb_pkg::ST_FULL1;
                    end else begin
                        n_ost = rpb_pkg::ST_FULLN;
                        n_cnt = r_com;
                    end
                end
            end
            rpb_pkg::S_OUT: begin
                // A row end commits the count unless the pixel stopped the region.
                if (r_last && (r_ost inside {rpb_pkg::ST_FOUND, rpb_pkg::ST_ADDED})) begin
                    n_com   = r_cnt;
                    n_first = 1'b0;
                end
                n_ov    = 1'b1;
                n_state = rpb_pkg::S_IDLE;
            end
            default: n_state = rpb_pkg::S_IDLE;
        endcase
    end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the row palette builder core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       region_start;
        logic       row_end;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]       color_index;
        rpb_pkg::t_status status;
        logic [8:0]       palette_length;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // red[7:0], green[15:8], blue[23:16]
    logic        s_axis_tlast = 1'b0;  // row_end
    logic        s_axis_tuser = 1'b0;  // first_of_region
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;  // color_index[7:0], palette_length[16:8], zeros
    logic [2:0]  m_axis_tuser;  // status

    row_palette_builder_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Palette shadow used to predict each answer.
    logic [23:0] shadow_colors [256];
    int unsigned shadow_count = 0;
    int unsigned shadow_committed = 0;
    bit          shadow_first_row = 1'b1;
    bit          shadow_stopped = 1'b0;

    t_pixel      pending_pixels[$];
    t_answer     expected_answers[$];
    int unsigned mismatch_count = 0;
    int unsigned answers_seen = 0;
    bit          hold_sink = 1'b0;
    bit          drain_sender = 1'b0;
    bit          in_fired = 1'b0;

    // Predict the answer to one pixel and update the shadow palette.
    function automatic t_answer palette_lookup(t_pixel px);
        t_answer     ans;
        logic [23:0] color;
        bit          hit;
        color = {px.red, px.green, px.blue};
        hit = 1'b0;
        ans.color_index = '0;
        if (px.region_start) begin
            shadow_count = 0;
            shadow_committed = 0;
            shadow_first_row = 1'b1;
            shadow_stopped = 1'b0;
        end
        if (shadow_stopped) begin
            ans.status = rpb_pkg::ST_IGNORED;
        end else begin
            for (int k = 0; k < shadow_count; k++) begin
                if (!hit && shadow_colors[k] == color) begin
                    hit = 1'b1;
                    ans.color_index = k[7:0];
                end
            end
            if (hit) begin
                ans.status = rpb_pkg::ST_FOUND;
            end else if (shadow_count < rpb_pkg::MaxColors) begin
                ans.color_index = shadow_count[7:0];
                shadow_colors[shadow_count] = color;
                shadow_count++;
                ans.status = rpb_pkg::ST_ADDED;
            end else if (shadow_first_row) begin
                shadow_stopped = 1'b1;
                ans.status = rpb_pkg::ST_FULL1;
            end else begin
                shadow_count = shadow_committed;
                shadow_stopped = 1'b1;
                ans.status = rpb_pkg::ST_FULLN;
            end
            if ((ans.status inside {rpb_pkg::ST_FOUND, rpb_pkg::ST_ADDED}) && px.row_end) begin
                shadow_committed = shadow_count;
                shadow_first_row = 1'b0;
            end
        end
        ans.palette_length = shadow_count[8:0];
        return ans;
    endfunction

    // Append one pixel to the stimulus queue.
    function automatic void queue_pixel(t_pixel px);
        pending_pixels = {pending_pixels, px};
    endfunction

    // Sender: one pixel from the queue, with a random gap before each.
    int unsigned send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fired) begin
                in_fired = 1'b0;
                s_axis_tvalid <= 1'b0;
                send_gap = $urandom_range(0, 6);
            end else if (!s_axis_tvalid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_pixels.size() > 0 &&
                             !(drain_sender && expected_answers.size() > 0)) begin
                    t_pixel px;
                    px = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= px.region_start;
                    s_axis_tlast <= px.row_end;
                    s_axis_tdata <= {px.blue, px.green, px.red};
                end
            end
        end
    end

    // Record the expected answer at each accepted pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_pixel px;
            px.region_start = s_axis_tuser;
            px.row_end = s_axis_tlast;
            px.red = s_axis_tdata[7:0];
            px.green = s_axis_tdata[15:8];
            px.blue = s_axis_tdata[23:16];
            expected_answers = {expected_answers, palette_lookup(px)};
            in_fired = 1'b1;
        end
    end

    // Receiver ready with random stalls, and a long hold-off on request.
    int unsigned sink_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && m_axis_tvalid) begin
                sink_gap = $urandom_range(0, 6);
                m_axis_tready <= (sink_gap == 0);
            end else if (!m_axis_tready) begin
                if (sink_gap > 0) sink_gap--;
                m_axis_tready <= (sink_gap == 0);
            end
        end
    end

    // Check each accepted answer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_answer want;
            answers_seen++;
            if (expected_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected answer: data=%h status=%0d", m_axis_tdata,
                             m_axis_tuser);
            end else begin
                want = expected_answers.pop_front();
                if (m_axis_tdata[7:0] !== want.color_index ||
                    m_axis_tdata[16:8] !== want.palette_length ||
                    m_axis_tdata[23:17] !== 7'd0 ||
                    m_axis_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: want idx=%0d st=%0d len=%0d ",
                                  "got idx=%0d st=%0d len=%0d"},
                                 want.color_index, want.status, want.palette_length,
                                 m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[16:8]);
                end
            end
        end
    end

    function automatic t_pixel make_pixel(bit rs, bit re, logic [23:0] rgb);
        t_pixel px;
        px.region_start = rs;
        px.row_end = re;
        {px.red, px.green, px.blue} = rgb;
        return px;
    endfunction

    // Queue one region: rows of pixels mostly drawn from a color pool of given size, some random.
    task automatic queue_region(int rows, int row_len, int pool, int unsigned base);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < row_len; c++) begin
                logic [23:0] rgb;
                rgb = 24'(base + $urandom_range(0, pool - 1) * 24'h010203);
                if ($urandom_range(0, 15) == 0) rgb = 24'($urandom);
                queue_pixel(make_pixel(r == 0 && c == 0, c == row_len - 1, rgb));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned target;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        m_axis_tready <= 1'b1;

        // Directed: extremes, hits, row commit, and pixels before any region flag.
        queue_pixel(make_pixel(0, 0, 24'h000000));
        queue_pixel(make_pixel(0, 0, 24'hFFFFFF));
        queue_pixel(make_pixel(0, 1, 24'h000000));
        queue_pixel(make_pixel(0, 0, 24'hFF00FF));
        queue_pixel(make_pixel(0, 1, 24'h00FF00));
        queue_pixel(make_pixel(1, 0, 24'h123456));
        queue_pixel(make_pixel(0, 1, 24'h123456));
        queue_pixel(make_pixel(1, 1, 24'hFFFFFF));
        wait_drained();

        // Fill on the first row: 256 new colors then one more stops the region.
        for (int k = 0; k < 257; k++)
            queue_pixel(make_pixel(k == 0, k == 256, 24'(k * 24'h010101 + 24'h0A)));
        queue_pixel(make_pixel(0, 1, 24'h0A));
        queue_pixel(make_pixel(1, 0, 24'h0A));

        // Full on a later row: commit 200 entries, then overflow and roll back.
        for (int k = 0; k < 200; k++)
            queue_pixel(make_pixel(k == 0, k == 199, 24'(24'h800000 + k)));
        for (int k = 0; k < 57; k++)
            queue_pixel(make_pixel(0, 1, 24'(24'h400000 + k)));
        queue_pixel(make_pixel(0, 0, 24'h300000));
        queue_pixel(make_pixel(0, 1, 24'h800005));

        // Long receiver hold-off while the sender keeps offering pixels.
        hold_sink = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_sink = 1'b0;
        wait_drained();

        // Random regions, mostly small palettes with some overflowing ones.
        target = 1300;
        while (answers_seen + pending_pixels.size() < target) begin
            if ($urandom_range(0, 7) == 0)
                queue_region($urandom_range(1, 3), $urandom_range(60, 140),
                             $urandom_range(200, 400), $urandom);
            else
                queue_region($urandom_range(1, 4), $urandom_range(1, 12),
                             $urandom_range(1, 20), $urandom);
            if ($urandom_range(0, 9) == 0)
                queue_pixel(make_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       24'($urandom)));
            if ($urandom_range(0, 5) == 0) begin
                drain_sender = 1'b1;
                wait_drained();
                drain_sender = 1'b0;
            end
        end
        wait_drained();
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("[row_palette_builder_core] OK");
        end else begin
            $display("[row_palette_builder_core] ERROR");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #20ms;
        $display("[row_palette_builder_core] ERROR");
        $finish;
    end

endmodule
